### rtl/core/iscl_pkg.sv
// shared types and constants for the sigma clipping limit finder
`default_nettype none
package iscl_pkg;

  localparam logic [30:0] ONE_Q16 = 31'd65536;

  typedef enum logic [1:0] {
    REG_SIGMA,
    REG_REMOVE,
    REG_TRIM,
    REG_MIN_STD
  } reg_idx_e;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } unit_rsp_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SUM,
    S_MEAN,
    S_MEAN_W,
    S_SQ,
    S_VAR,
    S_VAR_W,
    S_SQRT_W,
    S_KD,
    S_LIM1,
    S_LIM2,
    S_CLEAN,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

### rtl/core/iscl_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module iscl_ram #(
  parameter int unsigned Width = 33,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

### rtl/core/iscl_unit.sv
// shared bit serial divider and square root unit
`default_nettype none
module iscl_unit import iscl_pkg::*; #(
  parameter int unsigned OpW = 75,
  parameter int unsigned DvW = 11
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire unit_req_t      req_i,
  input  wire logic [OpW-1:0] opa_i,
  input  wire logic [DvW-1:0] divisor_i,
  output unit_rsp_t           rsp_o,
  output logic      [OpW-1:0] quo_o
);

  localparam int unsigned RW   = (DvW + 1 > 36) ? DvW + 1 : 36;
  localparam int unsigned CntW = $clog2(OpW + 1);

  logic            busy_q, done_q;
  unit_op_e        op_q;
  logic [CntW-1:0] cnt_q;
  logic [OpW-1:0]  acc_q, quo_q;
  logic [RW-1:0]   rem_q, rem_sh, sub;
  logic [DvW-1:0]  dvs_q;
  logic [RW:0]     diff;
  logic            ge;

  always_comb begin
    if (op_q == OP_DIV) begin
      rem_sh = {rem_q[RW-2:0], acc_q[OpW-1]};
      sub    = RW'(dvs_q);
    end else begin
      rem_sh = {rem_q[RW-3:0], acc_q[OpW-1 -: 2]};
      sub    = {quo_q[RW-3:0], 2'b01};
    end
    diff = {1'b0, rem_sh} - {1'b0, sub};
    ge   = !diff[RW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_DIV;
      cnt_q  <= '0;
      acc_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        rem_q  <= '0;
        quo_q  <= '0;
        dvs_q  <= divisor_i;
        if (req_i.op == OP_DIV) begin
          acc_q <= opa_i;
          cnt_q <= CntW'(OpW);
        end else begin
          acc_q <= {opa_i[63:0], {(OpW-64){1'b0}}};
          cnt_q <= CntW'(32);
        end
      end else if (busy_q) begin
        acc_q <= (op_q == OP_DIV) ? {acc_q[OpW-2:0], 1'b0} : {acc_q[OpW-3:0], 2'b00};
        rem_q <= ge ? diff[RW-1:0] : rem_sh;
        quo_q <= {quo_q[OpW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.rem_nz = |rem_q;
  assign quo_o        = quo_q;

endmodule
`default_nettype wire

### rtl/core/iterative_sigma_clip_limits_core.sv
// top level of the iterative sigma clipping limit finder
//
// channel  | direction | handshake                 | payload
// config   | in        | psel, penable, pwrite     | paddr, pwdata, prdata
// sample   | in        | start high and busy low   | sample_i, is_missing_i, last_i
// result   | out       | done_o, one cycle strobe  | limits, mean, deviation, counts
//
// samples load one per cycle; a request with last_i set starts the passes
// each statistics round and each cleaning pass reads all T stored samples
// the mean, variance and square root go through the shared divide/sqrt unit
// busy is high from the last request until the result strobe
// reset clears control state and restores the configuration defaults; the result cannot be stalled
`default_nettype none
module iterative_sigma_clip_limits_core import iscl_pkg::*; #(
  parameter int unsigned SAMPLE_DEPTH = 1024,
  parameter int unsigned MAX_PASSES   = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [3:0]                            paddr,
  input  wire logic [31:0]                           pwdata,
  output logic      [31:0]                           prdata,
  output logic                                       pready,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [31:0]                    sample_i,
  input  wire logic                                  is_missing_i,
  input  wire logic                                  last_i,
  output logic                                       done_o,
  output logic signed [31:0]                         trim_low_o,
  output logic signed [31:0]                         trim_high_o,
  output logic signed [31:0]                         remove_low_o,
  output logic signed [31:0]                         remove_high_o,
  output logic signed [31:0]                         final_mean_o,
  output logic [30:0]                                final_std_dev_o,
  output logic [$clog2(MAX_PASSES+1)-1:0]            pass_count_o,
  output logic                                       pass_limit_hit_o,
  output logic [$clog2(SAMPLE_DEPTH+1)-1:0]          kept_count_o
);

  localparam int unsigned CW = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);
  localparam int unsigned PW = $clog2(MAX_PASSES + 1);
  localparam int unsigned SW = 32 + CW;
  localparam int unsigned QW = 64 + CW;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    if (!v[40] && (|v[39:31])) begin
      return 32'sh7fffffff;
    end else if (v[40] && !(&v[39:31])) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  logic [15:0] sigma_q, min_std_q;
  logic        rem_en_q, trim_en_q;

  state_e                state_q, state_d;
  logic [CW-1:0]         total_q, total_d, rd_idx_q, rd_idx_d, n_q, n_d;
  logic [AW-1:0]         wb_idx_q;
  logic                  v1_q, v1_d, v2_q, v2_d, v3_q;
  logic signed [SW-1:0]  sum_q, sum_d;
  logic signed [31:0]    mean_q, mean_d;
  logic [31:0]           mag_q, mag_d;
  logic [63:0]           sq_q;
  logic [QW-1:0]         sqacc_q, sqacc_d;
  logic [30:0]           dev_q, dev_d;
  logic [38:0]           kd_q, kd_d;
  logic signed [31:0]    lt_q, lt_d, ut_q, ut_d, lr_q, lr_d, ur_q, ur_d;
  logic [PW-1:0]         passes_q, passes_d;
  logic                  changed_q, changed_d, fill_q, fill_d;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [32:0]           wdata, rdata;
  logic                  rd_miss, issue, accept;
  logic signed [31:0]    rd_val;
  logic                  sum_neg;
  logic [SW-1:0]         sum_mag;
  logic [32:0]           diff33, neg33, tmp33, neg_mean;
  logic [CW-1:0]         dvs;
  logic [30:0]           dev31;
  logic [46:0]           prod;

  unit_req_t             ureq;
  unit_rsp_t             ursp;
  logic [QW-1:0]         uopa, uquo;
  logic [CW-1:0]         udiv;

  iscl_ram #(.Width(33), .Depth(SAMPLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  iscl_unit #(.OpW(QW), .DvW(CW)) u_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ureq),
    .opa_i     (uopa),
    .divisor_i (udiv),
    .rsp_o     (ursp),
    .quo_o     (uquo)
  );

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_SIGMA:   prdata = {16'd0, sigma_q};
      REG_REMOVE:  prdata = {31'd0, rem_en_q};
      REG_TRIM:    prdata = {31'd0, trim_en_q};
      REG_MIN_STD: prdata = {16'd0, min_std_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q   <= 16'd768;
      rem_en_q  <= 1'b1;
      trim_en_q <= 1'b1;
      min_std_q <= 16'd66;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_SIGMA:   sigma_q   <= pwdata[15:0];
        REG_REMOVE:  rem_en_q  <= pwdata[0];
        REG_TRIM:    trim_en_q <= pwdata[0];
        REG_MIN_STD: min_std_q <= pwdata[15:0];
        default:     sigma_q   <= sigma_q;
      endcase
    end
  end

  assign busy    = (state_q != S_LOAD);
  assign accept  = start && !busy;
  assign rd_miss = rdata[32];
  assign rd_val  = rdata[31:0];
  assign sum_neg = sum_q[SW-1];
  assign sum_mag = sum_neg ? SW'(-sum_q) : SW'(sum_q);
  assign diff33  = {rd_val[31], rd_val} - {mean_q[31], mean_q};
  assign neg33   = -diff33;
  assign mag_d   = diff33[32] ? neg33[31:0] : diff33[31:0];
  assign tmp33   = {1'b0, uquo[31:0]} + {32'd0, ursp.rem_nz};
  assign neg_mean = -tmp33;
  assign dvs     = fill_q ? total_q : n_q;
  assign dev31   = uquo[31] ? {31{1'b1}} : uquo[30:0];
  assign prod    = 47'(sigma_q) * 47'(dev_q);
  assign v2_d    = (state_q == S_SQ) && v1_q && !rd_miss;

  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    rd_idx_d  = rd_idx_q;
    n_d       = n_q;
    sum_d     = sum_q;
    mean_d    = mean_q;
    sqacc_d   = sqacc_q;
    dev_d     = dev_q;
    kd_d      = kd_q;
    lt_d      = lt_q;
    ut_d      = ut_q;
    lr_d      = lr_q;
    ur_d      = ur_q;
    passes_d  = passes_q;
    changed_d = changed_q;
    fill_d    = fill_q;
    we        = 1'b0;
    waddr     = wb_idx_q;
    wdata     = {1'b0, rd_val};
    ureq      = '{start: 1'b0, op: OP_DIV};
    uopa      = sqacc_q;
    udiv      = dvs;
    issue     = 1'b0;

    case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (total_q < CW'(SAMPLE_DEPTH)) begin
            we      = 1'b1;
            waddr   = total_q[AW-1:0];
            wdata   = {is_missing_i, sample_i};
            total_d = total_q + 1'b1;
          end
          if (last_i) begin
            fill_d   = 1'b0;
            passes_d = '0;
            sum_d    = '0;
            n_d      = '0;
            state_d  = S_SUM;
          end
        end
      end
      S_SUM: begin
        issue = (rd_idx_q < total_q);
        if (v1_q && !rd_miss) begin
          sum_d = sum_q + {{(SW-32){rd_val[31]}}, rd_val};
          n_d   = n_q + 1'b1;
        end
        if (!issue && !v1_q) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        sqacc_d = '0;
        if (n_q == '0) begin
          mean_d  = '0;
          state_d = S_SQ;
        end else begin
          ureq    = '{start: 1'b1, op: OP_DIV};
          uopa    = {{(QW-SW){1'b0}}, sum_mag};
          udiv    = n_q;
          state_d = S_MEAN_W;
        end
      end
      S_MEAN_W: begin
        if (ursp.done) begin
          mean_d  = sum_neg ? neg_mean[31:0] : uquo[31:0];
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        issue = (rd_idx_q < total_q);
        if (v3_q) begin
          sqacc_d = sqacc_q + {{(QW-64){1'b0}}, sq_q};
        end
        if (!issue && !v1_q && !v2_q && !v3_q) begin
          state_d = S_VAR;
        end
      end
      S_VAR: begin
        if (dvs == '0) begin
          dev_d   = ONE_Q16;
          state_d = fill_q ? S_OUT : S_KD;
        end else begin
          ureq    = '{start: 1'b1, op: OP_DIV};
          state_d = S_VAR_W;
        end
      end
      S_VAR_W: begin
        if (ursp.done) begin
          ureq    = '{start: 1'b1, op: OP_SQRT};
          uopa    = {{(QW-64){1'b0}}, uquo[63:0]};
          state_d = S_SQRT_W;
        end
      end
      S_SQRT_W: begin
        if (ursp.done) begin
          dev_d   = (dev31 < 31'(min_std_q)) ? ONE_Q16 : dev31;
          state_d = fill_q ? S_OUT : S_KD;
        end
      end
      S_KD: begin
        kd_d    = prod[46:8];
        state_d = S_LIM1;
      end
      S_LIM1: begin
        lt_d    = sat32({{9{mean_q[31]}}, mean_q} - {2'b00, kd_q});
        ut_d    = sat32({{9{mean_q[31]}}, mean_q} + {2'b00, kd_q});
        state_d = S_LIM2;
      end
      S_LIM2: begin
        lr_d = sat32({{9{lt_q[31]}}, lt_q} - 41'sd65536);
        ur_d = sat32({{9{ut_q[31]}}, ut_q} + 41'sd65536);
        if (passes_q == PW'(MAX_PASSES)) begin
          fill_d  = 1'b1;
          sum_d   = '0;
          n_d     = '0;
          state_d = S_SUM;
        end else begin
          changed_d = 1'b0;
          state_d   = S_CLEAN;
        end
      end
      S_CLEAN: begin
        issue = (rd_idx_q < total_q);
        if (v1_q && !rd_miss) begin
          if (rem_en_q && (rd_val > ur_q || rd_val < lr_q)) begin
            we        = 1'b1;
            wdata     = {1'b1, rd_val};
            changed_d = 1'b1;
          end else if (trim_en_q && rd_val > ut_q) begin
            we        = 1'b1;
            wdata     = {1'b0, ut_q};
            changed_d = 1'b1;
          end else if (trim_en_q && rd_val < lt_q) begin
            we        = 1'b1;
            wdata     = {1'b0, lt_q};
            changed_d = 1'b1;
          end
        end
        if (!issue && !v1_q) begin
          sum_d   = '0;
          n_d     = '0;
          state_d = S_SUM;
          if (changed_q) begin
            passes_d = passes_q + 1'b1;
          end else begin
            fill_d = 1'b1;
          end
        end
      end
      S_OUT: begin
        total_d = '0;
        state_d = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase

    v1_d = issue;
    if (issue) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end
    if (state_d != state_q) begin
      rd_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      total_q   <= '0;
      rd_idx_q  <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      passes_q  <= '0;
      changed_q <= 1'b0;
      fill_q    <= 1'b0;
      n_q       <= '0;
      mean_q    <= '0;
      dev_q     <= ONE_Q16;
      lt_q      <= '0;
      ut_q      <= '0;
      lr_q      <= '0;
      ur_q      <= '0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      rd_idx_q  <= rd_idx_d;
      v1_q      <= v1_d;
      v2_q      <= v2_d;
      v3_q      <= v2_q;
      passes_q  <= passes_d;
      changed_q <= changed_d;
      fill_q    <= fill_d;
      n_q       <= n_d;
      mean_q    <= mean_d;
      dev_q     <= dev_d;
      lt_q      <= lt_d;
      ut_q      <= ut_d;
      lr_q      <= lr_d;
      ur_q      <= ur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_idx_q <= rd_idx_q[AW-1:0];
    sum_q    <= sum_d;
    mag_q    <= mag_d;
    sq_q     <= mag_q * mag_q;
    sqacc_q  <= sqacc_d;
    kd_q     <= kd_d;
  end

  assign done_o           = (state_q == S_OUT);
  assign trim_low_o       = lt_q;
  assign trim_high_o      = ut_q;
  assign remove_low_o     = lr_q;
  assign remove_high_o    = ur_q;
  assign final_mean_o     = mean_q;
  assign final_std_dev_o  = dev_q;
  assign pass_count_o     = passes_q;
  assign pass_limit_hit_o = (passes_q == PW'(MAX_PASSES));
  assign kept_count_o     = n_q;

endmodule
`default_nettype wire
